[src/hld_pkg.sv]
package hld_pkg;

    // default sizes of the accumulator and the peak list
    localparam int DEF_MAX_DIM    = 512;
    localparam int DEF_NUM_ANGLES = 180;
    localparam int DEF_MAX_LINES  = 64;

    // fixed field widths
    localparam int COORD_W = 9;
    localparam int VOTE_W  = 19;
    localparam int RHO_O_W = 12;
    localparam int ANGLE_W = 8;
    localparam int CFG_W   = 19;
    localparam int CIDX_W  = 3;

    localparam logic [VOTE_W-1:0] VOTE_MAX = '1;

    // pi in Q30 and the divisors of the sine and cosine series terms
    localparam longint unsigned PI_Q30 = 64'd3373259426;
    localparam longint unsigned SIN_DIV [12] = '{
        64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156,
        64'd210, 64'd272, 64'd342, 64'd420, 64'd506, 64'd600
    };
    localparam longint unsigned COS_DIV [12] = '{
        64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132,
        64'd182, 64'd240, 64'd306, 64'd380, 64'd462, 64'd552
    };

    // configuration register indexes
    localparam logic [CIDX_W-1:0] CFG_IMAGE_WIDTH    = 3'd0;
    localparam logic [CIDX_W-1:0] CFG_IMAGE_HEIGHT   = 3'd1;
    localparam logic [CIDX_W-1:0] CFG_VOTE_THRESHOLD = 3'd2;
    localparam logic [CIDX_W-1:0] CFG_LINES_MAX      = 3'd3;

    // register reset values
    localparam logic [9:0]        RST_IMAGE_WIDTH    = 10'd512;
    localparam logic [9:0]        RST_IMAGE_HEIGHT   = 10'd512;
    localparam logic [VOTE_W-1:0] RST_VOTE_THRESHOLD = 19'd200;
    localparam logic [6:0]        RST_LINES_MAX      = 7'd64;

    typedef struct packed {
        logic [COORD_W-1:0] pixel_x;
        logic [COORD_W-1:0] pixel_y;
        logic               edge_req;
        logic               frame_end;
    } t_pixel;

    typedef struct packed {
        logic                      found;
        logic signed [RHO_O_W-1:0] rho_offset;
        logic [ANGLE_W-1:0]        angle_index;
        logic [VOTE_W-1:0]         votes;
        logic                      last_line;
    } t_line;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DRAIN,
        ST_SCAN,
        ST_INS_START,
        ST_INS_RD,
        ST_INS_CMP,
        ST_INS_PUT,
        ST_EM_RD,
        ST_EM_LD,
        ST_EM_WAIT
    } t_state;

endpackage

[src/hough_line_detector_core.sv]
// Edge pixel: the accept step and then one accumulator read-modify-write per
// angle; a pixel that casts no vote takes only the accept step. Votes pass the
// table, product and address registers, then a read and a write.
// Frame end: drain, then a peak scan of 4 phases per cell, 2*(W+H)+2 cells per
// angle, on the single read port, plus start and put steps per insertion and read
// and compare steps per list entry compared, then read, load and wait steps per
// line beat, the wait held while the receiver stalls. A clearing pass after the
// lines and after reset zeroes the accumulator; reset is synchronous, active low.
module hough_line_detector_core
    import hld_pkg::*;
#(
    parameter int MAX_DIM    = DEF_MAX_DIM,
    parameter int NUM_ANGLES = DEF_NUM_ANGLES,
    parameter int MAX_LINES  = DEF_MAX_LINES
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  t_pixel            i_in,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output t_line             o_out,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [CIDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]  i_cfg_data
);

    localparam int RHO_SLOTS = 4 * MAX_DIM + 1;
    localparam int ACC_DEPTH = NUM_ANGLES * RHO_SLOTS;
    localparam int AW        = $clog2(ACC_DEPTH);
    localparam int RHO_W     = $clog2(RHO_SLOTS);
    localparam int ANG_W     = $clog2(NUM_ANGLES);
    localparam int DIM_W     = $clog2(MAX_DIM + 1);
    localparam int OFF_W     = DIM_W + 1;
    localparam int NR_W      = OFF_W + 1;
    localparam int RI_W      = ((OFF_W > 12) ? OFF_W : 12) + 2;
    localparam int PR_W      = COORD_W + 19;
    localparam int SUM_W     = PR_W + 1;
    localparam int CNT_W     = $clog2(MAX_LINES + 1);
    localparam int PI_W      = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
    localparam int PK_W      = VOTE_W + ANG_W + RHO_W;

    // sine or cosine of angle step n in Q16, from a Q30 series
    function automatic logic signed [17:0] trig_q16(input int n, input bit sel_sin);
        longint unsigned m, x, x2, st, ct, u;
        longint ss, cs, v;
        bit neg;
        int k;
        m   = longint'(n);
        neg = 1'b0;
        if (2 * n > NUM_ANGLES) begin
            m   = longint'(NUM_ANGLES - n);
            neg = 1'b1;
        end
        x  = (m * PI_Q30 + NUM_ANGLES / 2) / NUM_ANGLES;
        x2 = (x * x) >> 30;
        st = x;
        ct = 64'd1 << 30;
        ss = longint'(st);
        cs = longint'(ct);
        for (k = 1; k <= 12; k++) begin
            st = ((st * x2) >> 30) / SIN_DIV[k-1];
            ct = ((ct * x2) >> 30) / COS_DIV[k-1];
            if (k % 2 == 1) begin
                ss = ss - longint'(st);
                cs = cs - longint'(ct);
            end else begin
                ss = ss + longint'(st);
                cs = cs + longint'(ct);
            end
        end
        v = sel_sin ? ss : cs;
        if (v < 0) v = 0;
        u = (longint'(v) + 64'd8192) >> 14;
        if (u > 64'd65536) u = 64'd65536;
        if (!sel_sin && neg) return -18'(u);
        return 18'(u);
    endfunction

    // trig table
    logic signed [17:0] w_cos [NUM_ANGLES];
    logic signed [17:0] w_sin [NUM_ANGLES];
    for (genvar g = 0; g < NUM_ANGLES; g++) begin : g_rom
        assign w_cos[g] = trig_q16(g, 1'b0);
        assign w_sin[g] = trig_q16(g, 1'b1);
    end

    // configuration
    logic [9:0]        r_cfg_w, r_cfg_h;
    logic [VOTE_W-1:0] r_thr;
    logic [6:0]        r_lmax;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w <= RST_IMAGE_WIDTH;
            r_cfg_h <= RST_IMAGE_HEIGHT;
            r_thr   <= RST_VOTE_THRESHOLD;
            r_lmax  <= RST_LINES_MAX;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_IMAGE_WIDTH:    r_cfg_w <= i_cfg_data[9:0];
                CFG_IMAGE_HEIGHT:   r_cfg_h <= i_cfg_data[9:0];
                CFG_VOTE_THRESHOLD: r_thr   <= i_cfg_data[VOTE_W-1:0];
                CFG_LINES_MAX:      r_lmax  <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    // clamped geometry and line limit
    logic [DIM_W-1:0] w_wd, w_ht;
    logic [OFF_W-1:0] w_off;
    logic [NR_W-1:0]  w_numrho;
    logic [CNT_W-1:0] w_limit;

    always_comb begin
        w_wd = (r_cfg_w == '0) ? DIM_W'(1) :
               (r_cfg_w > MAX_DIM) ? DIM_W'(MAX_DIM) : DIM_W'(r_cfg_w);
        w_ht = (r_cfg_h == '0) ? DIM_W'(1) :
               (r_cfg_h > MAX_DIM) ? DIM_W'(MAX_DIM) : DIM_W'(r_cfg_h);
        w_off    = OFF_W'(w_wd) + OFF_W'(w_ht);
        w_numrho = {w_off, 1'b1};
        w_limit  = (r_lmax == '0) ? CNT_W'(1) :
                   (r_lmax > MAX_LINES) ? CNT_W'(MAX_LINES) : CNT_W'(r_lmax);
    end

    // state
    t_state r_state, n_state;

    // vote pipeline
    logic                   r_vbusy;
    logic [ANG_W-1:0]       r_ang;
    logic [AW-1:0]          r_base;
    logic [COORD_W-1:0]     r_px, r_py;
    logic                   r1_v, r2_v, r3_v, r4_v;
    logic signed [17:0]     r1_cos, r1_sin;
    logic [AW-1:0]          r1_base, r2_base, r3_addr, r4_addr;
    logic signed [PR_W-1:0] r2_mx, r2_my;

    // accumulator
    logic [VOTE_W-1:0] r_acc_mem [ACC_DEPTH];
    logic [VOTE_W-1:0] r_acc_q;
    logic              r_zero;
    logic [AW-1:0]     r_clr;

    // scan
    logic [ANG_W-1:0]  r_sn;
    logic [NR_W-1:0]   r_sc;
    logic [1:0]        r_ph;
    logic [AW-1:0]     r_sbase;
    logic [VOTE_W-1:0] r_left, r_cent, r_right, r_up;
    logic              r_scan_done;

    // peak list
    logic [PK_W-1:0]   r_pk_mem [MAX_LINES];
    logic [PK_W-1:0]   r_pk_q;
    logic [CNT_W-1:0]  r_pcount, r_pi, r_at, r_ei;
    logic [VOTE_W-1:0] r_pv;
    logic [ANG_W-1:0]  r_pa;
    logic [RHO_W-1:0]  r_pr;

    // output register
    logic  r_out_v;
    t_line r_out;

    logic              w_in_acc, w_drained;
    logic [VOTE_W-1:0] w_rd_val;
    logic              w_row_end, w_last_cell, w_peak;
    logic              w_pk_less;
    logic [AW-1:0]     w_rd_addr, w_wa;
    logic              w_scan_zero, w_we;
    logic [VOTE_W-1:0] w_wdat;
    logic [PI_W-1:0]   w_pk_ra, w_pk_wa;
    logic              w_pk_we;
    logic [PK_W-1:0]   w_pk_wd;

    assign o_in_stall  = !(r_state == ST_IDLE && !r_vbusy);
    assign w_in_acc    = i_in_valid && !o_in_stall;
    assign w_drained   = !r_vbusy && !r1_v && !r2_v && !r3_v && !r4_v;
    assign w_rd_val    = r_zero ? '0 : r_acc_q;
    assign w_row_end   = (r_sc == w_numrho);
    assign w_last_cell = w_row_end && (r_sn == ANG_W'(NUM_ANGLES - 1));
    assign w_peak      = (r_sc != '0) && (r_cent > r_thr) && (r_cent > r_left) &&
                         (r_cent >= r_right) && (r_cent > r_up) && (r_cent >= w_rd_val);
    assign w_pk_less   = r_pk_q[PK_W-1 -: VOTE_W] < r_pv;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: if (r_clr == AW'(ACC_DEPTH - 1)) n_state = ST_IDLE;
            ST_IDLE:  if (w_in_acc && i_in.frame_end) n_state = ST_DRAIN;
            ST_DRAIN: if (w_drained) n_state = ST_SCAN;
            ST_SCAN: begin
                if (r_ph == 2'd3) begin
                    if (w_peak) n_state = ST_INS_START;
                    else if (w_last_cell) n_state = ST_EM_RD;
                end
            end
            ST_INS_START: n_state = (r_pcount == '0) ? ST_INS_PUT : ST_INS_RD;
            ST_INS_RD:    n_state = ST_INS_CMP;
            ST_INS_CMP: begin
                if (w_pk_less && r_pi != '0) n_state = ST_INS_RD;
                else n_state = ST_INS_PUT;
            end
            ST_INS_PUT: n_state = r_scan_done ? ST_EM_RD : ST_SCAN;
            ST_EM_RD:   n_state = ST_EM_LD;
            ST_EM_LD:   n_state = ST_EM_WAIT;
            ST_EM_WAIT: begin
                if (!i_out_stall) n_state = r_out.last_line ? ST_CLEAR : ST_EM_RD;
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    // memory strobes and addresses
    always_comb begin
        w_rd_addr   = r3_addr;
        w_scan_zero = 1'b0;
        w_we        = r4_v;
        w_wa        = r4_addr;
        w_wdat      = (r_acc_q == VOTE_MAX) ? r_acc_q : r_acc_q + 1'b1;
        w_pk_ra     = r_pi[PI_W-1:0];
        w_pk_we     = 1'b0;
        w_pk_wa     = r_at[PI_W-1:0];
        w_pk_wd     = {r_pv, r_pa, r_pr};
        case (r_state)
            ST_CLEAR: begin
                w_we   = 1'b1;
                w_wa   = r_clr;
                w_wdat = '0;
            end
            ST_SCAN: begin
                case (r_ph)
                    2'd0: begin
                        w_rd_addr   = r_sbase + AW'(r_sc);
                        w_scan_zero = w_row_end;
                    end
                    2'd1: begin
                        w_rd_addr   = r_sbase - AW'(RHO_SLOTS) + AW'(r_sc) - AW'(1);
                        w_scan_zero = (r_sn == '0);
                    end
                    2'd2: begin
                        w_rd_addr   = r_sbase + AW'(RHO_SLOTS) + AW'(r_sc) - AW'(1);
                        w_scan_zero = (r_sn == ANG_W'(NUM_ANGLES - 1));
                    end
                    default: w_scan_zero = 1'b1;
                endcase
            end
            ST_INS_CMP: begin
                w_pk_we = w_pk_less && (CNT_W'(r_pi + 1'b1) < w_limit);
                w_pk_wa = PI_W'(r_pi + 1'b1);
                w_pk_wd = r_pk_q;
            end
            ST_INS_PUT: w_pk_we = (r_at < w_limit);
            ST_EM_RD:   w_pk_ra = r_ei[PI_W-1:0];
            default: ;
        endcase
    end

    // accumulator memory
    always_ff @(posedge i_clk) begin
        r_acc_q <= r_acc_mem[w_rd_addr];
        r_zero  <= w_scan_zero;
        if (w_we) r_acc_mem[w_wa] <= w_wdat;
    end

    // peak list memory
    always_ff @(posedge i_clk) begin
        r_pk_q <= r_pk_mem[w_pk_ra];
        if (w_pk_we) r_pk_mem[w_pk_wa] <= w_pk_wd;
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_clr   <= '0;
            r_vbusy <= 1'b0;
            r1_v    <= 1'b0;
            r2_v    <= 1'b0;
            r3_v    <= 1'b0;
            r4_v    <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= (r_state == ST_CLEAR) ? r_clr + 1'b1 : '0;
            // mark a pixel at work from its accept until its last angle
            if (r_vbusy && r_ang == ANG_W'(NUM_ANGLES - 1)) r_vbusy <= 1'b0;
            else if (w_in_acc && i_in.edge_req && i_in.pixel_x < w_wd &&
                     i_in.pixel_y < w_ht) r_vbusy <= 1'b1;
            r1_v <= r_vbusy;
            r2_v <= r1_v;
            r4_v <= r3_v;
            r_out_v <= (r_state == ST_EM_LD) ? 1'b1 :
                       (r_state == ST_EM_WAIT && !i_out_stall) ? 1'b0 : r_out_v;
            r3_v <= 1'b0;
            if (r2_v) begin
                logic signed [SUM_W-1:0] s, mag;
                logic signed [RI_W-1:0]  q, rio;
                s   = SUM_W'(r2_mx) + SUM_W'(r2_my) + SUM_W'(32768);
                mag = s[SUM_W-1] ? -s : s;
                q   = $signed(RI_W'(mag[SUM_W-2:16]));
                if (s[SUM_W-1]) q = -q;
                rio = q + $signed(RI_W'(w_off));
                r3_v <= (rio >= 0) && (rio < $signed(RI_W'(w_numrho)));
            end
        end
    end

    // vote datapath: table, products, rho and address
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_px   <= i_in.pixel_x;
            r_py   <= i_in.pixel_y;
            r_ang  <= '0;
            r_base <= '0;
        end else if (r_vbusy) begin
            r_ang  <= r_ang + 1'b1;
            r_base <= r_base + AW'(RHO_SLOTS);
        end
        r1_cos  <= w_cos[r_ang];
        r1_sin  <= w_sin[r_ang];
        r1_base <= r_base;
        r2_mx   <= $signed({1'b0, r_px}) * r1_cos;
        r2_my   <= $signed({1'b0, r_py}) * r1_sin;
        r2_base <= r1_base;
        begin
            logic signed [SUM_W-1:0] s2, mag2;
            logic signed [RI_W-1:0]  q2, rio2;
            s2   = SUM_W'(r2_mx) + SUM_W'(r2_my) + SUM_W'(32768);
            mag2 = s2[SUM_W-1] ? -s2 : s2;
            q2   = $signed(RI_W'(mag2[SUM_W-2:16]));
            if (s2[SUM_W-1]) q2 = -q2;
            rio2 = q2 + $signed(RI_W'(w_off));
            r3_addr <= r2_base + AW'(rio2[RHO_W-1:0]);
        end
        r4_addr <= r3_addr;
    end

    // scan, insertion and emission datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_DRAIN: begin
                r_sn        <= '0;
                r_sc        <= '0;
                r_ph        <= 2'd0;
                r_sbase     <= '0;
                r_left      <= '0;
                r_cent      <= '0;
                r_pcount    <= '0;
                r_scan_done <= 1'b0;
                r_ei        <= '0;
            end
            ST_SCAN: begin
                r_ph <= r_ph + 1'b1;
                if (r_ph == 2'd1) r_right <= w_rd_val;
                if (r_ph == 2'd2) r_up    <= w_rd_val;
                if (r_ph == 2'd3) begin
                    // latch a candidate, then advance along the row or on to the next angle
                    r_pv        <= r_cent;
                    r_pa        <= r_sn;
                    r_pr        <= RHO_W'(r_sc - 1'b1);
                    r_scan_done <= w_last_cell;
                    if (w_row_end) begin
                        r_sc    <= '0;
                        r_left  <= '0;
                        r_cent  <= '0;
                        r_sn    <= r_sn + 1'b1;
                        r_sbase <= r_sbase + AW'(RHO_SLOTS);
                    end else begin
                        r_sc   <= r_sc + 1'b1;
                        r_left <= r_cent;
                        r_cent <= r_right;
                    end
                end
            end
            ST_INS_START: begin
                r_at <= '0;
                r_pi <= r_pcount - 1'b1;
            end
            ST_INS_CMP: begin
                if (w_pk_less) begin
                    r_at <= '0;
                    r_pi <= r_pi - 1'b1;
                end else begin
                    r_at <= CNT_W'(r_pi + 1'b1);
                end
            end
            ST_INS_PUT: begin
                if (r_pcount < w_limit) r_pcount <= r_pcount + 1'b1;
                r_ei <= '0;
            end
            ST_EM_LD: begin
                if (r_pcount == '0) begin
                    r_out <= '{found: 1'b0, rho_offset: '0, angle_index: '0,
                               votes: '0, last_line: 1'b1};
                end else begin
                    logic signed [RI_W-1:0] ro;
                    ro = $signed(RI_W'(r_pk_q[RHO_W-1:0])) - $signed(RI_W'(w_off));
                    r_out.found       <= 1'b1;
                    r_out.rho_offset  <= ro[RHO_O_W-1:0];
                    r_out.angle_index <= ANGLE_W'(r_pk_q[RHO_W +: ANG_W]);
                    r_out.votes       <= r_pk_q[PK_W-1 -: VOTE_W];
                    r_out.last_line   <= (CNT_W'(r_ei + 1'b1) == r_pcount);
                end
            end
            ST_EM_WAIT: if (!i_out_stall) r_ei <= r_ei + 1'b1;
            default: ;
        endcase
    end

    assign o_out_valid = r_out_v;
    assign o_out       = r_out;

    // the two votes in the read and write stages never touch the same cell
    a_vote_hazard: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r3_v && r4_v) |-> (r3_addr != r4_addr))
        else $error("overlapping read-modify-write on one accumulator cell");

    // the peak scan runs only on a drained vote pipeline
    a_scan_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> w_drained)
        else $error("peak scan while votes are in flight");

    // a result beat is offered only while emitting
    a_out_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v |-> (r_state == ST_EM_WAIT))
        else $error("result valid outside emission");

    // the peak list never grows past the line limit
    a_pk_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_INS_PUT) |=> (r_pcount <= w_limit))
        else $error("peak list beyond line limit");

endmodule

[bench/tb_hough_line_detector_core.sv]
`timescale 1ns / 1ps

import hld_pkg::*;

// Line list predictor: accumulator, peak search and the queue of lines still owed
class line_scoreboard;
    localparam int ANGLES = 180;
    localparam int SLOTS  = 4 * 512 + 1;

    longint      cos_q [ANGLES];
    longint      sin_q [ANGLES];
    int unsigned vote_acc [];
    int unsigned pk_votes [64];
    int unsigned pk_pos [64];
    int unsigned pk_count;
    int unsigned width_r, height_r, thresh_r, lines_r;
    t_line       lines_owed [$];
    int          mismatches;
    int          lines_checked;
    int          frames_seen;
    int          pixels_seen;

    function new();
        vote_acc = new[ANGLES * SLOTS];
        foreach (vote_acc[i]) vote_acc[i] = 0;
        width_r  = 512;
        height_r = 512;
        thresh_r = 200;
        lines_r  = 64;
        build_trig();
    endfunction

    static function longint to_q16(longint v);
        longint unsigned u;
        if (v < 0) v = 0;
        u = (longint'(v) + 8192) >> 14;
        if (u > 65536) u = 65536;
        return longint'(u);
    endfunction

    // sine and cosine in Q2.16 from a Q30 series
    function void build_trig();
        int unsigned     m;
        bit              neg;
        longint unsigned x, x2, st, ct;
        longint          ss, cs;
        for (int n = 0; n < ANGLES; n++) begin
            m   = n;
            neg = 0;
            if (2 * n > ANGLES) begin
                m   = ANGLES - n;
                neg = 1;
            end
            x  = (longint'(m) * PI_Q30 + ANGLES / 2) / ANGLES;
            x2 = (x * x) >> 30;
            st = x;
            ct = 64'd1 << 30;
            ss = longint'(st);
            cs = longint'(ct);
            for (int k = 1; k <= 12; k++) begin
                st = ((st * x2) >> 30) / SIN_DIV[k-1];
                ct = ((ct * x2) >> 30) / COS_DIV[k-1];
                if (k % 2 == 1) begin
                    ss -= longint'(st);
                    cs -= longint'(ct);
                end else begin
                    ss += longint'(st);
                    cs += longint'(ct);
                end
            end
            sin_q[n] = to_q16(ss);
            cos_q[n] = neg ? -to_q16(cs) : to_q16(cs);
        end
    endfunction

    static function int unsigned clamp(int unsigned v, int unsigned lo, int unsigned hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function void write_reg(logic [CIDX_W-1:0] idx, logic [CFG_W-1:0] data);
        case (idx)
            CFG_IMAGE_WIDTH:    width_r  = data[9:0];
            CFG_IMAGE_HEIGHT:   height_r = data[9:0];
            CFG_VOTE_THRESHOLD: thresh_r = data;
            CFG_LINES_MAX:      lines_r  = data[6:0];
            default: ;
        endcase
    endfunction

    function int unsigned cell_at(int n, int r, int numrho);
        if (n < 0 || n >= ANGLES || r < 0 || r >= numrho) return 0;
        return vote_acc[n * SLOTS + r];
    endfunction

    function void insert_peak(int unsigned v, int unsigned pos, int unsigned limit);
        int unsigned at, last;
        at = pk_count;
        while (at > 0 && pk_votes[at-1] < v) at--;
        if (at >= limit) return;
        last = pk_count < limit ? pk_count : limit - 1;
        for (int unsigned i = last; i > at; i--) begin
            pk_votes[i] = pk_votes[i-1];
            pk_pos[i]   = pk_pos[i-1];
        end
        pk_votes[at] = v;
        pk_pos[at]   = pos;
        if (pk_count < limit) pk_count++;
    endfunction

    // note one accepted pixel beat: cast votes, and on frame end find the lines
    function void note_pixel(t_pixel p);
        int unsigned w, h, off, numrho, limit, v;
        longint      s, ri;
        t_line       ln;
        pixels_seen++;
        w      = clamp(width_r, 1, 512);
        h      = clamp(height_r, 1, 512);
        off    = w + h;
        numrho = 2 * off + 1;
        if (p.edge_req && p.pixel_x < w && p.pixel_y < h) begin
            for (int n = 0; n < ANGLES; n++) begin
                s  = longint'(p.pixel_x) * cos_q[n] + longint'(p.pixel_y) * sin_q[n]
                     + 32768;
                ri = s >= 0 ? (s >>> 16) : -((-s) >>> 16);
                ri += off;
                if (ri >= 0 && ri < numrho && vote_acc[n * SLOTS + ri] < 524287)
                    vote_acc[n * SLOTS + ri]++;
            end
        end
        if (!p.frame_end) return;

        frames_seen++;
        limit    = clamp(lines_r, 1, 64);
        pk_count = 0;
        for (int n = 0; n < ANGLES; n++) begin
            for (int r = 0; r < numrho; r++) begin
                v = vote_acc[n * SLOTS + r];
                if (v > thresh_r && v > cell_at(n, r - 1, numrho)
                        && v >= cell_at(n, r + 1, numrho)
                        && v > cell_at(n - 1, r, numrho)
                        && v >= cell_at(n + 1, r, numrho))
                    insert_peak(v, n * SLOTS + r, limit);
            end
        end
        foreach (vote_acc[i]) vote_acc[i] = 0;

        if (pk_count == 0) begin
            ln = '0;
            ln.last_line = 1'b1;
            lines_owed = {lines_owed, ln};
            return;
        end
        for (int unsigned i = 0; i < pk_count; i++) begin
            ln.found       = 1'b1;
            ln.rho_offset  = RHO_O_W'(int'(pk_pos[i] % SLOTS) - int'(off));
            ln.angle_index = ANGLE_W'(pk_pos[i] / SLOTS);
            ln.votes       = VOTE_W'(pk_votes[i]);
            ln.last_line   = (i + 1 == pk_count);
            lines_owed = {lines_owed, ln};
        end
    endfunction

    // compare one accepted line beat with the oldest one owed
    function void check_line(t_line got);
        t_line want;
        lines_checked++;
        if (lines_owed.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display({"line beat with none owed: ",
                          "found=%0b rho=%0d ang=%0d votes=%0d last=%0b"},
                         got.found, got.rho_offset, got.angle_index, got.votes,
                         got.last_line);
            return;
        end
        want = lines_owed.pop_front();
        if (got.found !== want.found || got.rho_offset !== want.rho_offset
                || got.angle_index !== want.angle_index || got.votes !== want.votes
                || got.last_line !== want.last_line) begin
            mismatches++;
            if (mismatches <= 10)
                $display({"line mismatch: want found=%0b rho=%0d ang=%0d votes=%0d last=%0b,",
                          " got found=%0b rho=%0d ang=%0d votes=%0d last=%0b"},
                         want.found, want.rho_offset, want.angle_index, want.votes,
                         want.last_line, got.found, got.rho_offset, got.angle_index,
                         got.votes, got.last_line);
        end
    endfunction
endclass

module tb_hough_line_detector_core;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_in_valid = 1'b0;
    logic              o_in_stall;
    t_pixel            i_in = '0;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    t_line             o_out;
    logic              i_cfg_valid = 1'b0;
    logic              o_cfg_ready;
    logic [CIDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0]  i_cfg_data = '0;

    line_scoreboard    sb;
    int                burst_left = 0;
    bit                hold_armed = 0;
    int                hold_left = 0;

    hough_line_detector_core i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic t_pixel pix(int x, int y, bit e, bit f);
        t_pixel p;
        p.pixel_x   = COORD_W'(x);
        p.pixel_y   = COORD_W'(y);
        p.edge_req  = e;
        p.frame_end = f;
        return p;
    endfunction

    // offer one pixel beat; bursts keep valid high, gaps lower it
    task automatic send_pixel(t_pixel p);
        int gap;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = $urandom_range(1, 12);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        i_in_valid <= 1'b1;
        i_in       <= p;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_pixel(p);
        burst_left--;
    endtask

    // offer one register write beat; the caller drops valid after the last one
    task automatic write_cfg(logic [CIDX_W-1:0] idx, logic [CFG_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, data);
    endtask

    // drop valid, wait for every owed line, then set up the next phase
    task automatic new_phase(int w, int h, int thr, int lmax);
        i_in_valid <= 1'b0;
        burst_left = 0;
        while (sb.lines_owed.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        write_cfg(CFG_IMAGE_WIDTH, CFG_W'(w));
        write_cfg(CFG_IMAGE_HEIGHT, CFG_W'(h));
        write_cfg(CFG_VOTE_THRESHOLD, CFG_W'(thr));
        write_cfg(CFG_LINES_MAX, CFG_W'(lmax));
        i_cfg_valid <= 1'b0;
    endtask

    // one frame: mostly points on a random line, some noise, last beat ends the frame
    task automatic random_frame(int w, int h, int count);
        int mode, k, x, y, t;
        mode = $urandom_range(0, 2);
        k    = $urandom_range(0, (w < h ? w : h) - 1);
        for (int i = 0; i < count; i++) begin
            t = $urandom_range(0, 511);
            if ($urandom_range(0, 9) < 7) begin
                case (mode)
                    0: begin x = t % w; y = k; end
                    1: begin x = k; y = t % h; end
                    default: begin x = t % w; y = (x + k) % h; end
                endcase
            end else begin
                x = $urandom_range(0, 511);
                y = $urandom_range(0, 511);
                if ($urandom_range(0, 1)) begin x = x % w; y = y % h; end
            end
            send_pixel(pix(x, y, $urandom_range(0, 9) != 0, i == count - 1));
        end
    endtask

    // line beat checking and the receiver's stall pattern
    initial begin : receiver
        logic [15:0] mask;
        int          ph;
        mask = '0;
        ph   = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall) sb.check_line(o_out);
            if (hold_armed && o_out_valid) begin
                hold_left  = 4000;
                hold_armed = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                if (ph == 0) begin
                    case ($urandom_range(0, 2))
                        0: mask = '0;
                        1: mask = 16'($urandom);
                        default: mask = 16'($urandom & $urandom);
                    endcase
                end
                i_out_stall <= mask[ph];
                ph = (ph + 1) % 16;
            end
        end
    end

    initial begin : watchdog
        #150_000_000;
        $display("tb_hough_line_detector_core: FAIL");
        $finish;
    end

    initial begin : stimulus
        int w, h, wait_cycles;
        sb = new();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // small image, zero threshold: many peaks, pixels outside, a non-edge beat
        new_phase(16, 16, 0, 64);
        send_pixel(pix(0, 0, 1, 0));
        send_pixel(pix(15, 15, 1, 0));
        send_pixel(pix(16, 3, 1, 0));
        send_pixel(pix(3, 16, 1, 0));
        send_pixel(pix(511, 511, 1, 0));
        send_pixel(pix(7, 7, 0, 0));
        send_pixel(pix(5, 5, 1, 1));

        // width and line limit below their ranges clamp up to one
        new_phase(0, 1, 0, 0);
        send_pixel(pix(0, 0, 1, 0));
        send_pixel(pix(0, 0, 1, 1));

        // top threshold: empty frame
        new_phase(1, 1, 524287, 1);
        send_pixel(pix(0, 0, 0, 1));

        // widest image, line limit above range
        new_phase(1023, 512, 1, 127);
        send_pixel(pix(100, 0, 1, 0));
        send_pixel(pix(200, 0, 1, 0));
        send_pixel(pix(511, 0, 1, 0));
        send_pixel(pix(300, 0, 1, 0));
        send_pixel(pix(0, 0, 1, 1));

        // random frames; the first is held off at the output while the next is offered
        w = $urandom_range(2, 48);
        h = $urandom_range(2, 48);
        new_phase(w, h, $urandom_range(0, 4), $urandom_range(1, 64));
        hold_armed = 1;
        random_frame(w, h, 40);
        random_frame(w, h, 40);
        w = $urandom_range(2, 48);
        h = $urandom_range(2, 48);
        new_phase(w, h, $urandom_range(0, 4), $urandom_range(1, 64));
        random_frame(w, h, 40);

        i_in_valid <= 1'b0;
        wait_cycles = 0;
        while (sb.lines_owed.size() != 0 && wait_cycles < 5_000_000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (1000) @(posedge i_clk);

        $display("run covered %0d pixel beats over %0d frames, %0d line beats checked",
                 sb.pixels_seen, sb.frames_seen, sb.lines_checked);
        $display("mismatches %0d, lines still owed %0d", sb.mismatches, sb.lines_owed.size());
        if (sb.mismatches == 0 && sb.lines_owed.size() == 0)
            $display("tb_hough_line_detector_core: PASS");
        else
            $display("tb_hough_line_detector_core: FAIL");
        $finish;
    end

endmodule

[filelist.f]
src/hld_pkg.sv
src/hough_line_detector_core.sv
bench/tb_hough_line_detector_core.sv
